// ===== design/bpl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared types and codes for the bounded positional list.
// ----------------------------------------------------------------------------
package bpl_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int POS_W        = 5;
	localparam int VAL_W        = 32;
	localparam int OUT_CNT_W    = 5;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5,
		OP_DUMP      = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		op_t                     operation;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] item_value;
		logic [OUT_CNT_W-1:0]    item_count;
		logic                    final_item;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic empty;
		logic dump_last;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/bpl_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpl_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bpl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/bpl_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpl_ctrl
// Controller: accepts requests and sequences the dump of the list.
// ----------------------------------------------------------------------------
module bpl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire bpl_pkg::op_t  req_op,
	output logic               req_ready,
	output bpl_pkg::cmd_t      cmd,
	input  wire bpl_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		req_ready = (state_q == S_IDLE) && sts.out_free;
		cmd.exec  = req_valid && req_ready;
		cmd.emit  = (state_q == S_DUMP) && sts.out_free;
		state_d   = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.exec && req_op == bpl_pkg::OP_DUMP && !sts.empty)
					state_d = S_DUMP;
			end
			S_DUMP: begin
				if (cmd.emit && sts.dump_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== design/bpl_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpl_datapath
// Shifting entry array, entry count, dump index and result register.
// ----------------------------------------------------------------------------
module bpl_datapath #(
	parameter int CAPACITY = bpl_pkg::DEF_CAPACITY
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bpl_pkg::req_t req_data,
	input  wire bpl_pkg::cmd_t cmd,
	output bpl_pkg::sts_t      sts,
	input  wire logic          out_ready,
	output logic               out_valid,
	output bpl_pkg::rsp_t      out_data
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = ((CNT_W > bpl_pkg::POS_W) ? CNT_W : bpl_pkg::POS_W) + 1;

	logic signed [bpl_pkg::VAL_W-1:0] ent_q [CAPACITY];
	logic [CNT_W-1:0]                 cnt_q, cnt_d;
	logic [IDX_W-1:0]                 dump_idx_q;
	logic                             out_valid_q;
	bpl_pkg::rsp_t                    out_data_q;

	logic [CMP_W-1:0]                 cnt_c, pos_c;
	logic                             full, empty, ins_pos_ok, del_pos_ok;
	logic                             do_ins, do_del, has_rsp, ins_ok, del_ok, load;
	bpl_pkg::status_t                 op_status;
	logic [IDX_W-1:0]                 op_idx, rd_idx;
	logic signed [bpl_pkg::VAL_W-1:0] rd_val;

	always_comb begin
		cnt_c      = CMP_W'(cnt_q);
		pos_c      = CMP_W'(req_data.position);
		full       = cnt_q == CNT_W'(CAPACITY);
		empty      = cnt_q == '0;
		ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + 1'b1);
		del_pos_ok = (pos_c != '0) && (pos_c <= cnt_c);
		do_ins     = 1'b0;
		do_del     = 1'b0;
		has_rsp    = 1'b0;
		op_status  = bpl_pkg::ST_OK;
		op_idx     = '0;
		unique case (req_data.operation)
			bpl_pkg::OP_INS_FRONT: begin
				has_rsp = 1'b1;
				if (full) op_status = bpl_pkg::ST_FULL;
				else do_ins = 1'b1;
			end
			bpl_pkg::OP_INS_BACK: begin
				has_rsp = 1'b1;
				op_idx  = IDX_W'(cnt_q);
				if (full) op_status = bpl_pkg::ST_FULL;
				else do_ins = 1'b1;
			end
			bpl_pkg::OP_INS_POS: begin
				has_rsp = 1'b1;
				op_idx  = IDX_W'(pos_c - 1'b1);
				if (full) op_status = bpl_pkg::ST_FULL;
				else if (!ins_pos_ok) op_status = bpl_pkg::ST_BADPOS;
				else do_ins = 1'b1;
			end
			bpl_pkg::OP_DEL_FRONT: begin
				has_rsp = 1'b1;
				if (empty) op_status = bpl_pkg::ST_EMPTY;
				else do_del = 1'b1;
			end
			bpl_pkg::OP_DEL_BACK: begin
				has_rsp = 1'b1;
				op_idx  = IDX_W'(cnt_q - 1'b1);
				if (empty) op_status = bpl_pkg::ST_EMPTY;
				else do_del = 1'b1;
			end
			bpl_pkg::OP_DEL_POS: begin
				has_rsp = 1'b1;
				op_idx  = IDX_W'(pos_c - 1'b1);
				if (empty) op_status = bpl_pkg::ST_EMPTY;
				else if (!del_pos_ok) op_status = bpl_pkg::ST_BADPOS;
				else do_del = 1'b1;
			end
			bpl_pkg::OP_DUMP: begin
				has_rsp   = empty;
				op_status = bpl_pkg::ST_EMPTY;
			end
			default: has_rsp = 1'b0;
		endcase
		ins_ok = cmd.exec && do_ins;
		del_ok = cmd.exec && do_del;
		cnt_d  = cnt_q + CNT_W'(ins_ok) - CNT_W'(del_ok);
		rd_idx = cmd.emit ? dump_idx_q : op_idx;
		rd_val = ent_q[rd_idx];
		load   = (cmd.exec && has_rsp) || cmd.emit;
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.empty     = empty;
	assign sts.dump_last = dump_idx_q == IDX_W'(cnt_q - 1'b1);

	// per-entry shift: insert moves entries up from op_idx, delete moves them down
	for (genvar i = 0; i < CAPACITY; i++) begin : g_ent
		logic signed [bpl_pkg::VAL_W-1:0] prev_w, next_w;
		if (i > 0) begin : g_prev
			assign prev_w = ent_q[i-1];
		end else begin : g_prev0
			assign prev_w = ent_q[i];
		end
		if (i < CAPACITY - 1) begin : g_next
			assign next_w = ent_q[i+1];
		end else begin : g_next0
			assign next_w = ent_q[i];
		end
		always_ff @(posedge clk) begin
			if (ins_ok) begin
				if (IDX_W'(i) == op_idx)
					ent_q[i] <= req_data.value;
				else if (IDX_W'(i) > op_idx)
					ent_q[i] <= prev_w;
			end else if (del_ok && IDX_W'(i) >= op_idx) begin
				ent_q[i] <= next_w;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			dump_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (cmd.exec)
				dump_idx_q <= '0;
			else if (cmd.emit)
				dump_idx_q <= dump_idx_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q.status     <= bpl_pkg::ST_OK;
			out_data_q.item_value <= rd_val;
			out_data_q.item_count <= bpl_pkg::OUT_CNT_W'(cnt_q);
			out_data_q.final_item <= sts.dump_last;
		end else if (cmd.exec && has_rsp) begin
			out_data_q.status     <= op_status;
			out_data_q.item_value <= del_ok ? rd_val : '0;
			out_data_q.item_count <= bpl_pkg::OUT_CNT_W'(cnt_d);
			out_data_q.final_item <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_exec_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !cmd.exec)
		else $error("request taken during dump");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not grow the list by one");

	a_dump_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("dump entry overwrote a pending result");

endmodule
`default_nettype wire

// ===== design/bounded_positional_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_positional_list
// Ordered list of up to CAPACITY signed 32-bit values with positional
// insert, delete and dump.
// ----------------------------------------------------------------------------
// Inserts, deletes and unused codes may follow one another every cycle as
// long as results are taken; each gives one transaction on rsp (none for an
// unused code). The entries sit in a register array that shifts all at once.
// A dump of a list with N entries holds req off until all N are out, one
// entry per cycle while results are taken, through the array's single read
// port, with final_item set on the last one; a dump of an empty list gives
// one empty-status result. Entry values come up undefined after reset; only
// the count, dump index and result valid are cleared, so no clearing pass.
// ----------------------------------------------------------------------------
module bounded_positional_list #(
	parameter int CAPACITY = bpl_pkg::DEF_CAPACITY
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bpl_stream_if.sink   req,
	bpl_stream_if.source rsp
);

	bpl_pkg::cmd_t cmd;
	bpl_pkg::sts_t sts;
	logic          req_ready;

	assign req.ready = req_ready;

	bpl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.payload.operation),
		.req_ready (req_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bpl_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.payload),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_data  (rsp.payload)
	);

endmodule
`default_nettype wire
